// ----- hw/rtl/itb_pkg.sv -----
`timescale 1ns / 1ps

package itb_pkg;

  // Fixed data formats
  localparam logic [16:0] BIN_MAX         = 17'h1FFFF;
  localparam logic [7:0]  START_THRESHOLD = 8'd127;

  // Input command codes
  localparam logic CMD_ANALYSE = 1'b0;
  localparam logic CMD_APPLY   = 1'b1;

  // Result kind codes
  localparam logic KIND_PIXEL  = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic       take;         // analyse beat accepted this cycle
    logic       apply;        // apply beat accepted this cycle
    logic       inc_wr;       // write back incremented bin
    logic       clr_wr;       // write zero at idx (reset sweep)
    logic       rd_issue;     // histogram read at idx feeds accumulators
    logic       rd_zero;      // clear the bin read at idx
    logic [7:0] idx;          // sweep address
    logic       acc_clr;      // clear class sums and counts
    logic       search_init;  // load the start threshold into the search
    logic       div_load_hi;  // load divider with upper class
    logic       div_load_lo;  // load divider with lower class
    logic       div_step;     // one quotient bit
    logic       next_t;       // take the new threshold
    logic       report;       // emit report, commit threshold and polarity
  } itb_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic converged;          // new threshold equals the current one
  } itb_stat_t;

endpackage

// ----- hw/rtl/itb_ctrl.sv -----
`timescale 1ns / 1ps

module itb_ctrl #(
  parameter int MAX_ITERATIONS = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             command,
  input  logic             last,
  input  itb_pkg::itb_stat_t stat,
  output logic             busy,
  output itb_pkg::itb_cmd_t  cmd
);

  localparam int IW = $clog2(MAX_ITERATIONS + 1);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_CLEAR    = 4'd1;
  localparam logic [3:0] S_INC      = 4'd2;
  localparam logic [3:0] S_SCAN     = 4'd3;
  localparam logic [3:0] S_SCAN_END = 4'd4;
  localparam logic [3:0] S_LOAD_HI  = 4'd5;
  localparam logic [3:0] S_DIV_HI   = 4'd6;
  localparam logic [3:0] S_LOAD_LO  = 4'd7;
  localparam logic [3:0] S_DIV_LO   = 4'd8;
  localparam logic [3:0] S_NEXT     = 4'd9;
  localparam logic [3:0] S_POL      = 4'd10;
  localparam logic [3:0] S_POL_END  = 4'd11;
  localparam logic [3:0] S_REPORT   = 4'd12;

  logic [3:0]    state, state_next;
  logic [7:0]    idx, idx_next;
  logic [2:0]    step, step_next;
  logic [IW-1:0] iter, iter_next;
  logic          last_pend, last_pend_next;

  // Advance state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      idx       <= '0;
      step      <= '0;
      iter      <= '0;
      last_pend <= 1'b0;
    end else begin
      state     <= state_next;
      idx       <= idx_next;
      step      <= step_next;
      iter      <= iter_next;
      last_pend <= last_pend_next;
    end
  end

  assign busy = (state != S_IDLE);

  // Decode state into datapath commands
  always_comb begin
    state_next     = state;
    idx_next       = idx;
    step_next      = step;
    iter_next      = iter;
    last_pend_next = last_pend;
    cmd            = '0;
    cmd.idx        = idx;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (command == itb_pkg::CMD_APPLY) begin
            cmd.apply = 1'b1;
          end else begin
            cmd.take       = 1'b1;
            last_pend_next = last;
            state_next     = S_INC;
          end
        end
      end
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        idx_next   = idx + 8'd1;
        if (idx == 8'hFF) state_next = S_IDLE;
      end
      S_INC: begin
        cmd.inc_wr = 1'b1;
        if (last_pend) begin
          cmd.acc_clr     = 1'b1;
          cmd.search_init = 1'b1;
          idx_next        = '0;
          iter_next       = '0;
          state_next      = S_SCAN;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.rd_issue = 1'b1;
        idx_next     = idx + 8'd1;
        if (idx == 8'hFF) state_next = S_SCAN_END;
      end
      S_SCAN_END: state_next = S_LOAD_HI;
      S_LOAD_HI: begin
        cmd.div_load_hi = 1'b1;
        step_next       = '0;
        state_next      = S_DIV_HI;
      end
      S_DIV_HI: begin
        cmd.div_step = 1'b1;
        step_next    = step + 3'd1;
        if (step == 3'd7) state_next = S_LOAD_LO;
      end
      S_LOAD_LO: begin
        cmd.div_load_lo = 1'b1;
        step_next       = '0;
        state_next      = S_DIV_LO;
      end
      S_DIV_LO: begin
        cmd.div_step = 1'b1;
        step_next    = step + 3'd1;
        if (step == 3'd7) state_next = S_NEXT;
      end
      S_NEXT: begin
        cmd.next_t  = 1'b1;
        cmd.acc_clr = 1'b1;
        idx_next    = '0;
        if (stat.converged || iter == IW'(MAX_ITERATIONS - 1)) begin
          state_next = S_POL;
        end else begin
          iter_next  = iter + 1'b1;
          state_next = S_SCAN;
        end
      end
      S_POL: begin
        cmd.rd_issue = 1'b1;
        cmd.rd_zero  = 1'b1;
        idx_next     = idx + 8'd1;
        if (idx == 8'hFF) state_next = S_POL_END;
      end
      S_POL_END: state_next = S_REPORT;
      S_REPORT: begin
        cmd.report = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- hw/rtl/itb_dpath.sv -----
`timescale 1ns / 1ps

module itb_dpath #(
  parameter int MAX_PIXELS = 65536
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        pixel,
  input  itb_pkg::itb_cmd_t   cmd,
  output itb_pkg::itb_stat_t  stat,
  output logic              done,
  output logic              kind,
  output logic              bin_pixel,
  output logic [7:0]        threshold,
  output logic              inverted
);

  localparam int CW = $clog2(MAX_PIXELS + 1);
  localparam int SW = CW + 8;

  logic [16:0]   hist [256];
  logic [16:0]   rdata;
  logic [7:0]    raddr;
  logic          we;
  logic [7:0]    waddr;
  logic [16:0]   wdata;

  logic [7:0]    addr_q;
  logic          take_ok;
  logic [CW-1:0] frame_cnt;
  logic          rd_vld;
  logic [7:0]    rd_v;
  logic [SW-1:0] hi_sum, lo_sum;
  logic [CW-1:0] hi_cnt, lo_cnt;
  logic [SW-1:0] rem, dsh;
  logic [7:0]    q;
  logic [7:0]    hi_mean;
  logic [7:0]    t_search;
  logic [7:0]    cur_t;
  logic          pol;
  logic [24:0]   prod;
  logic [8:0]    mean_sum;
  logic [7:0]    t_new;
  logic          more_black;

  // Select histogram ports
  assign raddr = cmd.take ? pixel : cmd.idx;
  assign we    = (cmd.inc_wr & take_ok) | cmd.clr_wr | cmd.rd_zero;
  assign waddr = cmd.inc_wr ? addr_q : cmd.idx;
  assign wdata = !cmd.inc_wr ? 17'd0 :
                 (rdata == itb_pkg::BIN_MAX) ? rdata : rdata + 17'd1;

  // Histogram memory
  always_ff @(posedge clk) begin
    rdata <= hist[raddr];
    if (we) hist[waddr] <= wdata;
  end

  assign prod       = rd_v * rdata;
  assign mean_sum   = {1'b0, hi_mean} + {1'b0, q};
  assign t_new      = mean_sum[8:1];
  assign more_black = (lo_cnt > hi_cnt);
  assign stat.converged = (t_new == t_search);

  // Hold pixel address and frame count
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_cnt <= '0;
    end else if (cmd.report) begin
      frame_cnt <= '0;
    end else if (cmd.take && frame_cnt != CW'(MAX_PIXELS)) begin
      frame_cnt <= frame_cnt + 1'b1;
    end
    if (cmd.take) begin
      addr_q  <= pixel;
      take_ok <= (frame_cnt != CW'(MAX_PIXELS));
    end
  end

  // Accumulate class sums and counts over a sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.rd_issue;
    end
    rd_v <= cmd.idx;
    if (cmd.acc_clr) begin
      hi_sum <= '0;
      lo_sum <= '0;
      hi_cnt <= '0;
      lo_cnt <= '0;
    end else if (rd_vld) begin
      if (rd_v > t_search) begin
        hi_sum <= hi_sum + SW'(prod);
        hi_cnt <= hi_cnt + CW'(rdata);
      end else begin
        lo_sum <= lo_sum + SW'(prod);
        lo_cnt <= lo_cnt + CW'(rdata);
      end
    end
  end

  // Divide class sum by count, one quotient bit per cycle; empty class gives 0
  always_ff @(posedge clk) begin
    if (cmd.div_load_hi) begin
      rem <= hi_sum;
      dsh <= SW'(hi_cnt) << 7;
      q   <= '0;
    end else if (cmd.div_load_lo) begin
      hi_mean <= q;
      rem     <= lo_sum;
      dsh     <= SW'(lo_cnt) << 7;
      q       <= '0;
    end else if (cmd.div_step) begin
      if (dsh != '0 && rem >= dsh) begin
        rem <= rem - dsh;
        q   <= {q[6:0], 1'b1};
      end else begin
        q <= {q[6:0], 1'b0};
      end
      dsh <= dsh >> 1;
    end
  end

  // Track search threshold
  always_ff @(posedge clk) begin
    if (cmd.search_init) begin
      t_search <= itb_pkg::START_THRESHOLD;
    end else if (cmd.next_t) begin
      t_search <= t_new;
    end
  end

  // Commit threshold and polarity at frame end
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_t <= itb_pkg::START_THRESHOLD;
      pol   <= 1'b0;
    end else if (cmd.report) begin
      cur_t <= t_search;
      pol   <= more_black;
    end
  end

  // Drive result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.apply | cmd.report;
    end
    if (cmd.report) begin
      kind      <= itb_pkg::KIND_REPORT;
      bin_pixel <= 1'b0;
      threshold <= t_search;
      inverted  <= more_black;
    end else begin
      kind      <= itb_pkg::KIND_PIXEL;
      bin_pixel <= (pixel > cur_t) ^ pol;
      threshold <= cur_t;
      inverted  <= pol;
    end
  end

endmodule

// ----- hw/rtl/isodata_threshold_binarizer.sv -----
`timescale 1ns / 1ps

// Isodata threshold binarizer. Stream a grey frame with command 0 (analyse)
// and mark its final pixel with last; then stream it with command 1 (apply)
// to get one binary pixel per beat. A beat is taken when start is high and
// busy is low; each result appears on the result ports for one cycle with
// done high, and the receiver cannot stall it. An apply result comes in the
// cycle after its beat, and the block stays ready for the next beat. An
// analyse beat holds busy high for the read-modify-write of the histogram
// memory. On the last pixel the block stays busy through N isodata
// iterations (at most MAX_ITERATIONS): each iteration sweeps the 256
// histogram bins through the single memory read port and then runs two
// divisions of eight quotient bits each; a final sweep counts the classes
// and clears the bins. The threshold report comes in the first cycle that
// busy is low again. After reset the block stays busy while it clears the
// histogram.

module isodata_threshold_binarizer #(
  parameter int MAX_PIXELS     = 65536,
  parameter int MAX_ITERATIONS = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic       command,
  input  logic [7:0] pixel,
  input  logic       last,
  output logic       done,
  output logic       kind,
  output logic       bin_pixel,
  output logic [7:0] threshold,
  output logic       inverted
);

  itb_pkg::itb_cmd_t  cmd;
  itb_pkg::itb_stat_t stat;

  itb_ctrl #(
    .MAX_ITERATIONS(MAX_ITERATIONS)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .command(command),
    .last   (last),
    .stat   (stat),
    .busy   (busy),
    .cmd    (cmd)
  );

  itb_dpath #(
    .MAX_PIXELS(MAX_PIXELS)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .pixel    (pixel),
    .cmd      (cmd),
    .stat     (stat),
    .done     (done),
    .kind     (kind),
    .bin_pixel(bin_pixel),
    .threshold(threshold),
    .inverted (inverted)
  );

endmodule

// ----- hw/rtl/itb_checker.sv -----
`timescale 1ns / 1ps

module itb_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       command,
  input logic [7:0] pixel,
  input logic       last,
  input logic       done,
  input logic       kind,
  input logic       bin_pixel,
  input logic [7:0] threshold,
  input logic       inverted
);

  // Apply beat yields a pixel result on the next cycle
  a_apply_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && command == itb_pkg::CMD_APPLY)
      |=> (done && kind == itb_pkg::KIND_PIXEL))
    else $error("apply beat gave no pixel result");

  // Analyse beat without last gives no result and holds the block busy
  a_analyse_quiet: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && command == itb_pkg::CMD_ANALYSE && !last)
      |=> (!done && busy))
    else $error("analyse beat produced a result or was not busy");

  // Any analyse beat, with or without last, holds the block busy, so no report follows at once
  a_analyse_last: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && command == itb_pkg::CMD_ANALYSE)
      |=> busy)
    else $error("analyse beat did not occupy the block");

  // Report carries no binary pixel
  a_report_pixel: assert property (@(posedge clk) disable iff (rst)
    (done && kind == itb_pkg::KIND_REPORT) |-> !bin_pixel)
    else $error("report with binary pixel set");

  // Pixel result agrees with its threshold and polarity
  a_pixel_value: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && command == itb_pkg::CMD_APPLY)
      |=> (bin_pixel == (($past(pixel) > threshold) ^ inverted)))
    else $error("binary pixel disagrees with threshold");

endmodule

bind isodata_threshold_binarizer itb_checker u_itb_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .command  (command),
  .pixel    (pixel),
  .last     (last),
  .done     (done),
  .kind     (kind),
  .bin_pixel(bin_pixel),
  .threshold(threshold),
  .inverted (inverted)
);
